@@ rtl/ssit_pkg.sv @@
package ssit_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF = 8;
    localparam int T_FRAC_BITS_DEF = 16;

endpackage

@@ rtl/ssit_div_cell.sv @@
module ssit_div_cell #(
    parameter int DEN_W = 35,
    parameter int T_W = 17,
    parameter int CW = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  valid,
    input  logic [DEN_W-1:0]      rem,
    input  logic [DEN_W-1:0]      den,
    input  logic [T_W-1:0]        quo,
    input  logic [3*CW-1:0]       bv,
    input  logic [3*CW-1:0]       cv,
    input  logic [3*(CW+1)-1:0]   dv,
    input  logic [CW-2:0]         rad,
    output logic                  valid_reg,
    output logic [DEN_W-1:0]      rem_reg,
    output logic [DEN_W-1:0]      den_reg,
    output logic [T_W-1:0]        quo_reg,
    output logic [3*CW-1:0]       bv_reg,
    output logic [3*CW-1:0]       cv_reg,
    output logic [3*(CW+1)-1:0]   dv_reg,
    output logic [CW-2:0]         rad_reg
);

    logic [DEN_W:0]   sh;
    logic [DEN_W-1:0] rem_next;
    logic [T_W-1:0]   quo_next;

    always_comb
    begin
        sh = {rem, 1'b0};
        if (sh >= {1'b0, den})
        begin
            rem_next = DEN_W'(sh - {1'b0, den});
            quo_next = {quo[T_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = sh[DEN_W-1:0];
            quo_next = {quo[T_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid;
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den;
        quo_reg <= quo_next;
        bv_reg  <= bv;
        cv_reg  <= cv;
        dv_reg  <= dv;
        rad_reg <= rad;
    end

endmodule

@@ rtl/segment_sphere_intersection_test_core.sv @@
// pipeline: stages 1 to 3, the row of divider cells, stages a to e, then the result register
// throughput: one word per cycle while in_ready is high, set by the row of divider cells, one quotient bit each
// ready stays high while fewer than T_FRAC_BITS + 11 words are in flight or the output drains
// with the output stalled, ready drops after 27 words at defaults
// reset: rst_n clears all valid flags and queue pointers at once; payload registers are not reset
module segment_sphere_intersection_test_core #(
    parameter int COORD_WIDTH = ssit_pkg::COORD_WIDTH_DEF,
    parameter int T_FRAC_BITS = ssit_pkg::T_FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] seg_begin_x,
    input  logic signed [COORD_WIDTH-1:0] seg_begin_y,
    input  logic signed [COORD_WIDTH-1:0] seg_begin_z,
    input  logic signed [COORD_WIDTH-1:0] seg_end_x,
    input  logic signed [COORD_WIDTH-1:0] seg_end_y,
    input  logic signed [COORD_WIDTH-1:0] seg_end_z,
    input  logic signed [COORD_WIDTH-1:0] center_x,
    input  logic signed [COORD_WIDTH-1:0] center_y,
    input  logic signed [COORD_WIDTH-1:0] center_z,
    input  logic [COORD_WIDTH-2:0]        radius,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          hit
);

    localparam int CW = COORD_WIDTH;
    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;
    localparam int DEN_W = PW + 2;
    localparam int T_W = T_FRAC_BITS + 1;
    localparam int MW = DW + T_W;
    localparam int SW = PW + 2;
    localparam int LAT = T_FRAC_BITS + 9;
    localparam int FILL_W = $clog2(LAT + 4);
    localparam int QW = $clog2(LAT + 2);
    localparam int QD = 1 << QW;

    logic [FILL_W-1:0] cnt_reg, cnt_next;

    // result queue
    logic q_mem [QD];
    logic [QW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QW:0] q_cnt_reg, q_cnt_next;
    logic ov_reg, ov_next;
    logic hit_reg;
    logic pop, out_free, q_push, q_pop, take_direct;

    // stage 1: differences
    logic v1_reg;
    logic signed [DW-1:0] d_reg [3];
    logic signed [DW-1:0] w_reg [3];
    logic signed [CW-1:0] b1_reg [3];
    logic signed [CW-1:0] c1_reg [3];
    logic [CW-2:0] r1_reg;

    // stage 2: products
    logic v2_reg;
    logic signed [PW-1:0] dw_reg [3];
    logic signed [PW-1:0] dd_reg [3];
    logic signed [CW-1:0] b2_reg [3];
    logic signed [CW-1:0] c2_reg [3];
    logic signed [DW-1:0] d2_reg [3];
    logic [CW-2:0] r2_reg;

    // stage 3: sums and clamp decision
    logic v3_reg;
    logic signed [DEN_W-1:0] num_reg, den_reg;

    logic signed [DEN_W-1:0] num_next, den_next;
    logic [DEN_W-1:0] rem0, den0;
    logic [T_W-1:0] quo0;

    logic signed [CW-1:0] b3_reg [3];
    logic signed [CW-1:0] c3_reg [3];
    logic signed [DW-1:0] d3_reg [3];
    logic [CW-2:0] r3_reg;

    logic cv_ok [T_FRAC_BITS+1];
    logic [DEN_W-1:0] crem [T_FRAC_BITS+1];
    logic [DEN_W-1:0] cden [T_FRAC_BITS+1];
    logic [T_W-1:0] cquo [T_FRAC_BITS+1];
    logic [3*CW-1:0] cb [T_FRAC_BITS+1];
    logic [3*CW-1:0] cc [T_FRAC_BITS+1];
    logic [3*DW-1:0] cd [T_FRAC_BITS+1];
    logic [CW-2:0] cr [T_FRAC_BITS+1];

    // stage a: t select
    logic va_reg;
    logic [T_W-1:0] ta_reg;
    logic signed [CW-1:0] ba_reg [3];
    logic signed [CW-1:0] ca_reg [3];
    logic signed [DW-1:0] da_reg [3];
    logic [CW-2:0] ra_reg;

    // stage b: d*t
    logic vb_reg;
    logic signed [MW-1:0] m_reg [3];
    logic signed [CW-1:0] bb_reg [3];
    logic signed [CW-1:0] cb2_reg [3];
    logic [CW-2:0] rb_reg;

    // stage c: diff
    logic vc_reg;
    logic signed [DW+1:0] df_reg [3];
    logic [CW-2:0] rc_reg;

    // stage d: squares
    logic vd_reg;
    logic [PW+3:0] sq_reg [3];
    logic [2*CW-3:0] rr_reg;

    // stage e: compare
    logic ve_reg;
    logic he_reg;

    assign in_ready = (cnt_reg < FILL_W'(LAT + 2)) || (out_valid && out_ready);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (in_valid && in_ready && !(out_valid && out_ready))
            cnt_next = cnt_reg + 1'b1;
        else if (!(in_valid && in_ready) && out_valid && out_ready)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            v1_reg <= in_valid && in_ready;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            va_reg <= cv_ok[T_FRAC_BITS];
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
            ve_reg <= vd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg[0] <= DW'(seg_end_x) - DW'(seg_begin_x);
        d_reg[1] <= DW'(seg_end_y) - DW'(seg_begin_y);
        d_reg[2] <= DW'(seg_end_z) - DW'(seg_begin_z);
        w_reg[0] <= DW'(center_x) - DW'(seg_begin_x);
        w_reg[1] <= DW'(center_y) - DW'(seg_begin_y);
        w_reg[2] <= DW'(center_z) - DW'(seg_begin_z);
        b1_reg[0] <= seg_begin_x;
        b1_reg[1] <= seg_begin_y;
        b1_reg[2] <= seg_begin_z;
        c1_reg[0] <= center_x;
        c1_reg[1] <= center_y;
        c1_reg[2] <= center_z;
        r1_reg <= radius;
        for (int i = 0; i < 3; i++)
        begin
            dw_reg[i] <= PW'(d_reg[i]) * PW'(w_reg[i]);
            dd_reg[i] <= PW'(d_reg[i]) * PW'(d_reg[i]);
            b2_reg[i] <= b1_reg[i];
            c2_reg[i] <= c1_reg[i];
            d2_reg[i] <= d_reg[i];
            b3_reg[i] <= b2_reg[i];
            c3_reg[i] <= c2_reg[i];
            d3_reg[i] <= d2_reg[i];
        end
        r2_reg <= r1_reg;
        r3_reg <= r2_reg;
        num_reg <= num_next;
        den_reg <= den_next;
    end

    assign num_next = DEN_W'(dw_reg[0]) + DEN_W'(dw_reg[1]) + DEN_W'(dw_reg[2]);
    assign den_next = DEN_W'(dd_reg[0]) + DEN_W'(dd_reg[1]) + DEN_W'(dd_reg[2]);

    // quotient bit T_FRAC_BITS set flags t = 1; low bits zero then
    always_comb
    begin
        if (den_reg == '0 || num_reg <= 0)
        begin
            rem0 = '0;
            den0 = {{(DEN_W-1){1'b0}}, 1'b1};
            quo0 = '0;
        end
        else if (num_reg >= den_reg)
        begin
            rem0 = '0;
            den0 = {{(DEN_W-1){1'b0}}, 1'b1};
            quo0 = '1;
        end
        else
        begin
            rem0 = num_reg;
            den0 = den_reg;
            quo0 = '0;
        end
    end

    assign cv_ok[0] = v3_reg;
    assign crem[0] = rem0;
    assign cden[0] = den0;
    assign cquo[0] = quo0;
    assign cb[0] = {b3_reg[2], b3_reg[1], b3_reg[0]};
    assign cc[0] = {c3_reg[2], c3_reg[1], c3_reg[0]};
    assign cd[0] = {d3_reg[2], d3_reg[1], d3_reg[0]};
    assign cr[0] = r3_reg;

    for (genvar g = 0; g < T_FRAC_BITS; g++)
    begin : g_cell
        ssit_div_cell #(
            .DEN_W (DEN_W),
            .T_W   (T_W),
            .CW    (CW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid     (cv_ok[g]),
            .rem       (crem[g]),
            .den       (cden[g]),
            .quo       (cquo[g]),
            .bv        (cb[g]),
            .cv        (cc[g]),
            .dv        (cd[g]),
            .rad       (cr[g]),
            .valid_reg (cv_ok[g+1]),
            .rem_reg   (crem[g+1]),
            .den_reg   (cden[g+1]),
            .quo_reg   (cquo[g+1]),
            .bv_reg    (cb[g+1]),
            .cv_reg    (cc[g+1]),
            .dv_reg    (cd[g+1]),
            .rad_reg   (cr[g+1])
        );
    end

    // quotient bit T_FRAC_BITS set marks t = 1 (a true quotient is below 2^T_FRAC_BITS)
    always_ff @(posedge clk)
    begin
        if (cquo[T_FRAC_BITS][T_W-1])
            ta_reg <= T_W'(1) << T_FRAC_BITS;
        else
            ta_reg <= cquo[T_FRAC_BITS];
        for (int i = 0; i < 3; i++)
        begin
            ba_reg[i] <= cb[T_FRAC_BITS][i*CW +: CW];
            ca_reg[i] <= cc[T_FRAC_BITS][i*CW +: CW];
            da_reg[i] <= cd[T_FRAC_BITS][i*DW +: DW];
            m_reg[i] <= MW'(da_reg[i]) * $signed({1'b0, ta_reg});
            bb_reg[i] <= ba_reg[i];
            cb2_reg[i] <= ca_reg[i];
            df_reg[i] <= (DW+2)'(cb2_reg[i]) - (DW+2)'(bb_reg[i])
                         - (DW+2)'(m_reg[i] >>> T_FRAC_BITS);
            sq_reg[i] <= (PW+4)'(df_reg[i]) * (PW+4)'(df_reg[i]);
        end
        ra_reg <= cr[T_FRAC_BITS];
        rb_reg <= ra_reg;
        rc_reg <= rb_reg;
        rr_reg <= (2*CW-2)'(rc_reg) * (2*CW-2)'(rc_reg);
        he_reg <= (SW+2)'(sq_reg[0]) + (SW+2)'(sq_reg[1]) + (SW+2)'(sq_reg[2])
                  <= (SW+2)'(rr_reg);
    end

    // result queue holds finished words the output cannot take; an empty queue passes straight to the output
    always_comb
    begin
        pop = out_valid && out_ready;
        out_free = !ov_reg || pop;
        q_pop = out_free && (q_cnt_reg != '0);
        take_direct = out_free && (q_cnt_reg == '0) && ve_reg;
        q_push = ve_reg && !take_direct;
        ov_next = ov_reg;
        if (out_free)
            ov_next = q_pop || take_direct;
        wr_ptr_next = wr_ptr_reg + QW'(q_push);
        rd_ptr_next = rd_ptr_reg + QW'(q_pop);
        q_cnt_next = q_cnt_reg;
        if (q_push && !q_pop)
            q_cnt_next = q_cnt_reg + 1'b1;
        else if (!q_push && q_pop)
            q_cnt_next = q_cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            q_cnt_reg <= '0;
        end
        else
        begin
            ov_reg <= ov_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            q_cnt_reg <= q_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
            q_mem[wr_ptr_reg] <= he_reg;
        if (q_pop)
            hit_reg <= q_mem[rd_ptr_reg];
        else if (take_direct)
            hit_reg <= he_reg;
    end

    assign out_valid = ov_reg;
    assign hit = hit_reg;

endmodule

@@ rtl/ssit_checker.sv @@
module ssit_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic hit
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit))
        else $error("result word changed while stalled");

    // output draining always frees input side
    a_ready_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |-> in_ready)
        else $error("input not ready while output drains");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result word during reset");

endmodule

bind segment_sphere_intersection_test_core ssit_checker u_ssit_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hit       (hit)
);

@@ tb/testbench.sv @@
module testbench;

    localparam int CW = ssit_pkg::COORD_WIDTH_DEF;
    localparam int TF = ssit_pkg::T_FRAC_BITS_DEF;
    localparam int LATENCY = TF + 9;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_RANDOM = 1280;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct {
        coord_t bx, by, bz, ex, ey, ez, cx, cy, cz;
        logic [CW-2:0] rad;
    } query_t;

    typedef struct {
        query_t q;
        int hit;
    } row_t;

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic out_ready = 0;
    coord_t seg_begin_x = 0, seg_begin_y = 0, seg_begin_z = 0;
    coord_t seg_end_x = 0, seg_end_y = 0, seg_end_z = 0;
    coord_t center_x = 0, center_y = 0, center_z = 0;
    logic [CW-2:0] radius = 0;
    logic in_ready, out_valid, hit;

    bit expected_hits[$];
    int errors = 0;
    int cycles = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_hits = 0;
    bit long_hold = 0;
    bit done_sending = 0;

    segment_sphere_intersection_test_core i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .seg_begin_x(seg_begin_x), .seg_begin_y(seg_begin_y), .seg_begin_z(seg_begin_z),
        .seg_end_x(seg_end_x), .seg_end_y(seg_end_y), .seg_end_z(seg_end_z),
        .center_x(center_x), .center_y(center_y), .center_z(center_z),
        .radius(radius),
        .out_valid(out_valid), .out_ready(out_ready), .hit(hit)
    );

    always #4 clk = ~clk;

    function automatic longint floor_div_pow2(longint v, int s);
        if (v >= 0)
            return v >>> s;
        return -((-(v + 1)) >>> s) - 1;
    endfunction

    function automatic bit segment_touches(query_t q);
        longint b[3], c[3], d[3], w[3];
        longint num, den, t, r, p, diff;
        longint unsigned dist2, rr;
        num = 0;
        den = 0;
        dist2 = 0;
        b[0] = longint'(q.bx); b[1] = longint'(q.by); b[2] = longint'(q.bz);
        c[0] = longint'(q.cx); c[1] = longint'(q.cy); c[2] = longint'(q.cz);
        d[0] = longint'(q.ex) - b[0];
        d[1] = longint'(q.ey) - b[1];
        d[2] = longint'(q.ez) - b[2];
        for (int i = 0; i < 3; i++)
        begin
            w[i] = c[i] - b[i];
            num += d[i] * w[i];
            den += d[i] * d[i];
        end
        if (den == 0 || num <= 0)
            t = 0;
        else if (num >= den)
            t = longint'(1) << TF;
        else
        begin
            r = num;
            t = 0;
            for (int i = 0; i < TF; i++)
            begin
                r = r << 1;
                t = t << 1;
                if (r >= den)
                begin
                    r -= den;
                    t |= 1;
                end
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            p = b[i] + floor_div_pow2(d[i] * t, TF);
            diff = c[i] - p;
            if (diff < 0)
                diff = -diff;
            dist2 += longint'(diff) * diff;
        end
        rr = longint'(q.rad) * longint'(q.rad);
        return dist2 <= rr;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at cycle %0d: %s", cycles, what);
        errors++;
    endtask

    function automatic coord_t rand_coord(int mode);
        case (mode)
            0: return coord_t'($urandom);
            1: return coord_t'($urandom_range(0, 2047) - 1024);
            default: return coord_t'($urandom_range(0, 127) - 64);
        endcase
    endfunction

    function automatic query_t rand_query();
        query_t q;
        int mode;
        mode = $urandom_range(0, 2);
        q.bx = rand_coord(mode); q.by = rand_coord(mode); q.bz = rand_coord(mode);
        if ($urandom_range(0, 15) == 0)
        begin
            q.ex = q.bx; q.ey = q.by; q.ez = q.bz;
        end
        else
        begin
            q.ex = rand_coord(mode); q.ey = rand_coord(mode); q.ez = rand_coord(mode);
        end
        q.cx = rand_coord(mode); q.cy = rand_coord(mode); q.cz = rand_coord(mode);
        if (mode == 0)
            q.rad = (CW-1)'($urandom);
        else
            q.rad = (CW-1)'($urandom_range(0, mode == 1 ? 1500 : 80));
        return q;
    endfunction

    function automatic query_t make_query(int bx, int by, int bz, int ex, int ey, int ez,
                                          int cx, int cy, int cz, int rad);
        query_t q;
        q.bx = coord_t'(bx); q.by = coord_t'(by); q.bz = coord_t'(bz);
        q.ex = coord_t'(ex); q.ey = coord_t'(ey); q.ez = coord_t'(ez);
        q.cx = coord_t'(cx); q.cy = coord_t'(cy); q.cz = coord_t'(cz);
        q.rad = (CW-1)'(rad);
        return q;
    endfunction

    task automatic send_word(query_t q);
        seg_begin_x <= q.bx; seg_begin_y <= q.by; seg_begin_z <= q.bz;
        seg_end_x <= q.ex; seg_end_y <= q.ey; seg_end_z <= q.ez;
        center_x <= q.cx; center_y <= q.cy; center_z <= q.cz;
        radius <= q.rad;
        in_valid <= 1;
        expected_hits.push_back(segment_touches(q));
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        n_sent++;
    endtask

    task automatic idle_cycles(int n);
        in_valid <= 0;
        repeat (n) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_hits.size() == 0)
                report_mismatch("result word with nothing expected");
            else
            begin
                bit want;
                want = expected_hits.pop_front();
                if (hit !== want)
                    report_mismatch($sformatf("hit %b, expected %b", hit, want));
                n_checked++;
                n_hits += want;
            end
        end
    end

    // receiver stall pattern, with one long hold-off
    initial
    begin
        int stall_run;
        stall_run = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
                out_ready <= 0;
            else if (stall_run > 0)
            begin
                out_ready <= 0;
                stall_run--;
            end
            else if (cycles % 600 < 150)
                out_ready <= 1;
            else if ($urandom_range(0, 7) == 0)
            begin
                out_ready <= 0;
                stall_run = $urandom_range(0, 5);
            end
            else
                out_ready <= 1;
        end
    end

    initial
    begin
        row_t rows[$];
        query_t q;
        int burst;
        int mx, mn;
        mx = (1 << (CW - 1)) - 1;
        mn = -(1 << (CW - 1));
        rows.push_back('{make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1});
        rows.push_back('{make_query(0, 0, 0, 0, 0, 0, 1, 0, 0, 0), 0});
        rows.push_back('{make_query(5, 5, 5, 5, 5, 5, 8, 9, 5, 5), 1});
        rows.push_back('{make_query(0, 0, 0, 100, 0, 0, -50, 0, 0, 49), 0});
        rows.push_back('{make_query(0, 0, 0, 100, 0, 0, -50, 0, 0, 50), 1});
        rows.push_back('{make_query(0, 0, 0, 100, 0, 0, 150, 0, 0, 50), 1});
        rows.push_back('{make_query(0, 0, 0, 100, 0, 0, 150, 0, 0, 49), 0});
        rows.push_back('{make_query(0, 0, 0, 100, 0, 0, 50, 30, 0, 30), 1});
        rows.push_back('{make_query(0, 0, 0, 100, 0, 0, 50, 30, 0, 29), 0});
        rows.push_back('{make_query(0, 0, 0, -100, -30, 7, -33, -11, 2, 3), -1});
        rows.push_back('{make_query(3, -7, 1, -9, 4, -13, -1, 0, -5, 2), -1});
        rows.push_back('{make_query(mn, mn, mn, mx, mx, mx, 0, 0, 0, 0), -1});
        rows.push_back('{make_query(mx, mx, mx, mn, mn, mn, mx, mn, mx, 32767), -1});
        rows.push_back('{make_query(mn, mn, mn, mn, mn, mn, mx, mx, mx, 32767), 0});
        rows.push_back('{make_query(mx, mn, mx, mn, mx, mn, -1, -1, -1, 32767), -1});
        rows.push_back('{make_query(-1, -1, -1, -1, -1, -1, -1, -1, -1, 0), 1});
        rows.push_back('{make_query(0, 0, 0, 3, 0, 0, 1, 1, 0, 1), -1});
        rows.push_back('{make_query(0, 0, 0, -3, 0, 0, -1, 1, 0, 1), -1});
        rows.push_back('{make_query(mn, 0, 0, mx, 0, 0, 0, mn, mx, 32767), -1});
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        foreach (rows[i])
        begin
            if (rows[i].hit >= 0 && segment_touches(rows[i].q) != rows[i].hit)
                report_mismatch($sformatf("predictor disagrees on directed row %0d", i));
            send_word(rows[i].q);
        end
        idle_cycles(1);
        // pause until everything drains
        while (expected_hits.size() != 0)
            @(posedge clk);
        // long hold-off while words keep coming
        long_hold = 1;
        fork
            begin
                repeat (LATENCY * 3) @(posedge clk);
                long_hold = 0;
            end
            for (int i = 0; i < 60; i++)
                send_word(rand_query());
        join
        while (n_sent < N_RANDOM + rows.size())
        begin
            burst = $urandom_range(1, 40);
            for (int i = 0; i < burst; i++)
                send_word(rand_query());
            if ($urandom_range(0, 2) != 0)
                idle_cycles($urandom_range(1, 6));
        end
        idle_cycles(1);
        done_sending = 1;
        while (expected_hits.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
        $display("sent %0d words: directed extremes, degenerate and clamped segments, random",
                 n_sent);
        $display("checked %0d result words, %0d of them hits", n_checked, n_hits);
        if (errors == 0 && expected_hits.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
